>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define PMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmt check failed");

// Next-cycle implication under an active-low reset.
`define PMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmt check failed");

`endif

>>> rtl/core/pmt_pkg.sv
// Types and codes of the pending message timeout table.
package pmt_pkg;

    localparam int unsigned SID_W  = 32;
    localparam int unsigned NUM_W  = 32;
    localparam int unsigned TYP_W  = 8;
    localparam int unsigned AGE_W  = 16;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned PCNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PURGE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PURGE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd5;

    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd10;

    typedef struct packed {
        logic [SID_W-1:0] session;
        logic [NUM_W-1:0] number;
        logic [TYP_W-1:0] mtype;
        logic [AGE_W-1:0] age;
    } t_entry;

endpackage

>>> rtl/core/pending_message_timeout_table.sv
// Pending message table with add, remove, session purge and timeout tick.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  in      | input     | i_valid / o_ready     | command, session, number, type
//  out     | output    | o_valid / i_ready     | kind, found, entry, purged count, last
//  cfg     | input     | i_cfg_valid / o_cfg_ready | timeout in ticks
//
//  Add is accepted in S_IDLE and written in S_ADD. Remove, purge and tick are accepted
//  in S_IDLE, read each entry in S_READ and S_EVAL and close in S_READ; each entry moved
//  into a hole goes through S_MOVE_READ and S_MOVE_WR, and a remove that finds its key
//  ends after the move without the close. The entry memory has a registered read port.
//  One item is worked at a time; o_ready is high only while the table is idle.
//  Results wait in the output register; a full register stalls any step that emits one.
//  Synchronous reset empties the table and restores the timeout to 10 ticks.
module pending_message_timeout_table #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pmt_pkg::CMD_W-1:0]   i_command,
    input  logic [pmt_pkg::SID_W-1:0]   i_session_id,
    input  logic [pmt_pkg::NUM_W-1:0]   i_message_number,
    input  logic [pmt_pkg::TYP_W-1:0]   i_message_type,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pmt_pkg::KIND_W-1:0]  o_result_kind,
    output logic                        o_found,
    output logic [pmt_pkg::SID_W-1:0]   o_out_session_id,
    output logic [pmt_pkg::NUM_W-1:0]   o_out_message_number,
    output logic [pmt_pkg::TYP_W-1:0]   o_out_message_type,
    output logic [pmt_pkg::PCNT_W-1:0]  o_purged_count,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pmt_pkg::AGE_W-1:0]   i_cfg_data
);
    import pmt_pkg::*;

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_ADD       = 6'b000010,
        S_READ      = 6'b000100,
        S_EVAL      = 6'b001000,
        S_MOVE_READ = 6'b010000,
        S_MOVE_WR   = 6'b100000
    } t_state;

    t_entry mem [TABLE_DEPTH];
    t_entry r_rd;

    t_state            r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [SID_W-1:0]  r_sid, n_sid;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [TYP_W-1:0]  r_typ, n_typ;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_wr_idx, n_wr_idx;
    logic [CW-1:0]     r_count, n_count;
    logic [PCNT_W-1:0] r_purged, n_purged;
    logic [AGE_W-1:0]  r_timeout, n_timeout;

    logic              r_ov, n_ov;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic              r_found, n_found;
    logic [SID_W-1:0]  r_osid, n_osid;
    logic [NUM_W-1:0]  r_onum, n_onum;
    logic [TYP_W-1:0]  r_otyp, n_otyp;
    logic [PCNT_W-1:0] r_opc, n_opc;
    logic              r_olast, n_olast;

    logic              mem_we, mem_re;
    logic [IW-1:0]     mem_wa, mem_ra;
    t_entry            mem_wd;
    logic              out_free;
    logic [AGE_W-1:0]  age_inc;
    logic [CW-1:0]     last_idx;

    assign out_free = !r_ov || i_ready;
    assign age_inc  = (&r_rd.age) ? r_rd.age : r_rd.age + AGE_W'(1);
    assign last_idx = r_count - ONE_C;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_sid     = r_sid;
        n_num     = r_num;
        n_typ     = r_typ;
        n_idx     = r_idx;
        n_wr_idx  = r_wr_idx;
        n_count   = r_count;
        n_purged  = r_purged;
        n_timeout = r_timeout;
        n_ov      = r_ov && !i_ready;
        n_kind    = r_kind;
        n_found   = r_found;
        n_osid    = r_osid;
        n_onum    = r_onum;
        n_otyp    = r_otyp;
        n_opc     = r_opc;
        n_olast   = r_olast;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wa    = r_idx[IW-1:0];
        mem_ra    = r_idx[IW-1:0];
        mem_wd    = r_rd;

        if (i_cfg_valid) begin
            n_timeout = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_command;
                    n_sid    = i_session_id;
                    n_num    = i_message_number;
                    n_typ    = i_message_type;
                    n_idx    = '0;
                    n_wr_idx = '0;
                    n_purged = '0;
                    n_state  = (i_command == CMD_ADD) ? S_ADD : S_READ;
                end
            end
            S_ADD: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_found = 1'b0;
                    n_osid  = '0;
                    n_onum  = '0;
                    n_otyp  = '0;
                    n_opc   = '0;
                    n_olast = 1'b1;
                    if (r_count >= DEPTH_C) begin
                        n_kind = KIND_FULL;
                    end else begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[IW-1:0];
                        mem_wd  = '{session: r_sid, number: r_num, mtype: r_typ, age: '0};
                        n_count = r_count + ONE_C;
                        n_kind  = KIND_ADDED;
                    end
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (r_idx < r_count) begin
                    mem_re  = 1'b1;
                    n_state = S_EVAL;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_found = 1'b0;
                    n_osid  = '0;
                    n_onum  = '0;
                    n_otyp  = '0;
                    n_opc   = '0;
                    n_olast = 1'b1;
                    case (r_cmd)
                        CMD_REMOVE: n_kind = KIND_REMOVE;
                        CMD_PURGE: begin
                            n_kind  = KIND_PURGE;
                            n_opc   = r_purged;
                            n_count = r_wr_idx;
                        end
                        default: n_kind = KIND_TICK_DONE;
                    endcase
                    n_state = S_IDLE;
                end
            end
            S_EVAL: begin
                case (r_cmd)
                    CMD_REMOVE: begin
                        if (r_rd.session == r_sid && r_rd.number == r_num) begin
                            n_state = S_MOVE_READ;
                        end else begin
                            n_idx   = r_idx + ONE_C;
                            n_state = S_READ;
                        end
                    end
                    CMD_PURGE: begin
                        if (r_rd.session == r_sid) begin
                            n_purged = r_purged + PCNT_W'(1);
                        end else begin
                            mem_we   = 1'b1;
                            mem_wa   = r_wr_idx[IW-1:0];
                            n_wr_idx = r_wr_idx + ONE_C;
                        end
                        n_idx   = r_idx + ONE_C;
                        n_state = S_READ;
                    end
                    default: begin
                        if (age_inc >= r_timeout) begin
                            if (out_free) begin
                                n_ov    = 1'b1;
                                n_kind  = KIND_TIMEOUT;
                                n_found = 1'b0;
                                n_osid  = r_rd.session;
                                n_onum  = r_rd.number;
                                n_otyp  = r_rd.mtype;
                                n_opc   = '0;
                                n_olast = 1'b0;
                                n_state = S_MOVE_READ;
                            end
                        end else begin
                            mem_we     = 1'b1;
                            mem_wd.age = age_inc;
                            n_idx      = r_idx + ONE_C;
                            n_state    = S_READ;
                        end
                    end
                endcase
            end
            S_MOVE_READ: begin
                mem_re  = 1'b1;
                mem_ra  = last_idx[IW-1:0];
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                if (r_cmd != CMD_REMOVE) begin
                    mem_we  = 1'b1;
                    n_count = last_idx;
                    n_state = S_READ;
                end else if (out_free) begin
                    mem_we  = 1'b1;
                    n_count = last_idx;
                    n_ov    = 1'b1;
                    n_kind  = KIND_REMOVE;
                    n_found = 1'b1;
                    n_osid  = '0;
                    n_onum  = '0;
                    n_otyp  = '0;
                    n_opc   = '0;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_timeout <= TIMEOUT_RESET;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_timeout <= n_timeout;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_sid    <= n_sid;
        r_num    <= n_num;
        r_typ    <= n_typ;
        r_idx    <= n_idx;
        r_wr_idx <= n_wr_idx;
        r_purged <= n_purged;
        r_kind   <= n_kind;
        r_found  <= n_found;
        r_osid   <= n_osid;
        r_onum   <= n_onum;
        r_otyp   <= n_otyp;
        r_opc    <= n_opc;
        r_olast  <= n_olast;
    end

    assign o_ready              = (r_state == S_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_valid              = r_ov;
    assign o_result_kind        = r_kind;
    assign o_found              = r_found;
    assign o_out_session_id     = r_osid;
    assign o_out_message_number = r_onum;
    assign o_out_message_type   = r_otyp;
    assign o_purged_count       = r_opc;
    assign o_last               = r_olast;

endmodule

>>> rtl/core/pmt_checker.sv
// Port-level checks of the pending message timeout table, bound to the table module.
`include "assert_macros.svh"

module pmt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [pmt_pkg::KIND_W-1:0]  o_result_kind,
    input logic                        o_found,
    input logic                        o_last
);
    import pmt_pkg::*;

    `PMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `PMT_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `PMT_ASSERT_SAME(a_timeout_not_last, i_clk, i_rst_n, o_valid && o_result_kind == KIND_TIMEOUT, !o_last)
    `PMT_ASSERT_SAME(a_found_remove, i_clk, i_rst_n, o_valid && o_found, o_result_kind == KIND_REMOVE)
endmodule

bind pending_message_timeout_table pmt_checker u_pmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_kind (o_result_kind),
    .o_found       (o_found),
    .o_last        (o_last)
);
